// File: src/cover_crop_window_assert.svh
// ----------------------------------------------------------------------------
// cover_crop_window assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef COVER_CROP_WINDOW_ASSERT_SVH
`define COVER_CROP_WINDOW_ASSERT_SVH

// a in a cycle implies b in the same cycle
`define CCW_ASSERT_IMP(lbl, c, r, a, b) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
	else $error("cover_crop_window check failed");

// a in a cycle implies b in the next one
`define CCW_ASSERT_NXT(lbl, c, r, a, b) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) \
	else $error("cover_crop_window check failed");

`endif

// File: src/ccw_pkg.sv
// ----------------------------------------------------------------------------
// ccw_pkg
// Constants shared by the crop window datapath.
// ----------------------------------------------------------------------------
package ccw_pkg;
	localparam int DIM_BITS_DEF  = 16;
	localparam int FRAC_BITS_DEF = 8;
	localparam int FIELD_W       = 16;
	localparam int OUT_W         = 24;
	localparam int ZOOM_FRAC     = 8;
	localparam int PAN_FRAC      = 12;
	localparam int IN_DATA_W     = 7 * FIELD_W;
	localparam int OUT_DATA_W    = 4 * OUT_W;
endpackage

// File: src/cover_crop_window.sv
// ----------------------------------------------------------------------------
// cover_crop_window
// Aspect-fill source rectangle with zoom and pan, fully pipelined.
// ----------------------------------------------------------------------------
// channel  dir  width  contents
// s_*      in   112    request: frame/image size, pan, zoom
// m_*      out  96+1   rectangle, valid flag in m_tuser
//
// One request per cycle while the output register is empty or taken. The pipe
// holds the crop divider (DIM_BITS+FRAC_BITS cells) and the zoom dividers
// (DIM_BITS+FRAC_BITS+8 cells). Whole pipe advances while the output
// register is empty or taken; a held output stalls all stages.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module cover_crop_window
	import ccw_pkg::*;
#(
	parameter int DIM_BITS  = DIM_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// frame_width, frame_height, image_width, image_height, pan_x, pan_y, zoom
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// rect_left, rect_top, rect_width, rect_height
	output logic [OUT_DATA_W-1:0] m_tdata,
	// rect_valid
	output logic                  m_tuser
);
	localparam int LW  = DIM_BITS + FRAC_BITS;
	localparam int AW  = LW + ZOOM_FRAC;
	localparam int PW1 = 2 * DIM_BITS + 3 * FIELD_W + 2;
	localparam int PWX = 2 * LW + 1 + FIELD_W + 1;
	localparam int PWY = 2 * LW + 1 + FIELD_W;

	logic                 en;
	logic [FIELD_W-1:0]   f_fw, f_fh, f_iw, f_ih, f_px, f_py, f_zm;
	logic [DIM_BITS-1:0]  fw, fh, iw, ih;
	logic                 v_s1, bad_s1;
	logic [DIM_BITS-1:0]  fw_s1, fh_s1, iw_s1, ih_s1;
	logic [FIELD_W-1:0]   px_s1, py_s1, zm_s1;
	logic [2*DIM_BITS-1:0] pw_s1, ph_s1;
	logic                 wide;
	logic [2*DIM_BITS-1:0] prod;
	logic [DIM_BITS-1:0]  den1;
	logic [PW1-1:0]       pl1_in, pl1_out;
	logic                 v_d1;
	logic [LW-1:0]        want;
	logic [DIM_BITS-1:0]  d_iw, d_ih;
	logic                 d_wide, d_bad;
	logic [FIELD_W-1:0]   d_zm, d_px, d_py;
	logic [LW-1:0]        img_w, img_h, sx, sy, lx, ly;
	logic [LW:0]          cx, cy;
	logic [PWX-1:0]       plx_in, plx_out;
	logic [PWY-1:0]       ply_in, ply_out;
	logic                 v_dx, v_dy;
	logic [AW-1:0]        qx, qy;
	logic [LW:0]          ax_cen, ay_cen;
	logic [LW-1:0]        ax_lim, ay_lim;
	logic [FIELD_W-1:0]   ax_pan, ay_pan;
	logic                 ax_bad;
	logic [LW-1:0]        lo_x, lo_y, sz_x, sz_y;
	logic [2:0]           v_dl_q, bad_dl_q;
	logic                 m_tvalid_q, m_tuser_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;

	assign {f_zm, f_py, f_px, f_ih, f_iw, f_fh, f_fw} = s_tdata;
	assign fw = DIM_BITS'(f_fw);
	assign fh = DIM_BITS'(f_fh);
	assign iw = DIM_BITS'(f_iw);
	assign ih = DIM_BITS'(f_ih);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_s1 <= (fw == '0) || (fh == '0) || (iw == '0) || (ih == '0) ||
			          f_zm[FIELD_W-1] || (f_zm == '0);
			fw_s1 <= fw;
			fh_s1 <= fh;
			iw_s1 <= iw;
			ih_s1 <= ih;
			px_s1 <= f_px;
			py_s1 <= f_py;
			zm_s1 <= f_zm;
			pw_s1 <= iw * fh;
			ph_s1 <= fw * ih;
		end
	end

	always_comb begin
		wide   = pw_s1 > ph_s1;
		prod   = wide ? ph_s1 : pw_s1;
		den1   = wide ? fh_s1 : fw_s1;
		pl1_in = {iw_s1, ih_s1, wide, bad_s1, zm_s1, px_s1, py_s1};
	end

	ccw_div #(.DW(DIM_BITS), .QW(LW), .PW(PW1)) u_div_crop (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_s1),
		.in_rem  (prod[2*DIM_BITS-1:DIM_BITS]),
		.in_num  ({prod[DIM_BITS-1:0], {FRAC_BITS{1'b0}}}),
		.in_den  (den1),
		.in_pl   (pl1_in),
		.out_v   (v_d1),
		.out_quo (want),
		.out_pl  (pl1_out)
	);

	always_comb begin
		{d_iw, d_ih, d_wide, d_bad, d_zm, d_px, d_py} = pl1_out;
		img_w = {d_iw, {FRAC_BITS{1'b0}}};
		img_h = {d_ih, {FRAC_BITS{1'b0}}};
		if (d_wide) begin
			sx = LW'((img_w - want) >> 1);
			lx = want;
			sy = '0;
			ly = img_h;
		end else begin
			sx = '0;
			lx = img_w;
			sy = LW'((img_h - want) >> 1);
			ly = want;
		end
		cx     = {1'b0, sx} + {2'b0, lx[LW-1:1]};
		cy     = {1'b0, sy} + {2'b0, ly[LW-1:1]};
		plx_in = {cx, img_w, d_px, d_bad};
		ply_in = {cy, img_h, d_py};
	end

	ccw_div #(.DW(FIELD_W), .QW(AW), .PW(PWX)) u_div_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_d1),
		.in_rem  ('0),
		.in_num  ({lx, {ZOOM_FRAC{1'b0}}}),
		.in_den  (d_zm),
		.in_pl   (plx_in),
		.out_v   (v_dx),
		.out_quo (qx),
		.out_pl  (plx_out)
	);

	ccw_div #(.DW(FIELD_W), .QW(AW), .PW(PWY)) u_div_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_d1),
		.in_rem  ('0),
		.in_num  ({ly, {ZOOM_FRAC{1'b0}}}),
		.in_den  (d_zm),
		.in_pl   (ply_in),
		.out_v   (v_dy),
		.out_quo (qy),
		.out_pl  (ply_out)
	);

	assign {ax_cen, ax_lim, ax_pan, ax_bad} = plx_out;
	assign {ay_cen, ay_lim, ay_pan}         = ply_out;

	ccw_place #(.LW(LW), .AW(AW)) u_place_x (
		.clk    (clk),
		.en     (en),
		.quo    (qx),
		.centre (ax_cen),
		.limit  (ax_lim),
		.pan    (ax_pan),
		.lo     (lo_x),
		.size   (sz_x)
	);

	ccw_place #(.LW(LW), .AW(AW)) u_place_y (
		.clk    (clk),
		.en     (en),
		.quo    (qy),
		.centre (ay_cen),
		.limit  (ay_lim),
		.pan    (ay_pan),
		.lo     (lo_y),
		.size   (sz_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_dl_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			v_dl_q     <= {v_dl_q[1:0], v_dx & v_dy};
			m_tvalid_q <= v_dl_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_dl_q  <= {bad_dl_q[1:0], ax_bad};
			m_tuser_q <= !bad_dl_q[2];
			if (bad_dl_q[2]) begin
				m_tdata_q <= '0;
			end else begin
				m_tdata_q <= {OUT_W'(sz_y), OUT_W'(sz_x), OUT_W'(lo_y), OUT_W'(lo_x)};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
endmodule

// File: src/ccw_div_cell.sv
// ----------------------------------------------------------------------------
// ccw_div_cell
// One restoring division step: one quotient bit, registered.
// ----------------------------------------------------------------------------
module ccw_div_cell #(
	parameter int DW = 16,
	parameter int QW = 24,
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [DW-1:0] in_rem,
	input  logic [QW-1:0] in_sh,
	input  logic [DW-1:0] in_den,
	input  logic [PW-1:0] in_pl,
	output logic          out_v,
	output logic [DW-1:0] out_rem,
	output logic [QW-1:0] out_sh,
	output logic [DW-1:0] out_den,
	output logic [PW-1:0] out_pl
);
	logic [DW:0]   cat;
	logic [DW:0]   diff;
	logic          qb;
	logic [DW-1:0] rem_n;
	logic [QW-1:0] sh_n;
	logic          v_q;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] sh_q;
	logic [DW-1:0] den_q;
	logic [PW-1:0] pl_q;

	always_comb begin
		cat   = {in_rem, in_sh[QW-1]};
		diff  = cat - {1'b0, in_den};
		qb    = (cat >= {1'b0, in_den});
		rem_n = qb ? diff[DW-1:0] : cat[DW-1:0];
		sh_n  = {in_sh[QW-2:0], qb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= rem_n;
			sh_q  <= sh_n;
			den_q <= in_den;
			pl_q  <= in_pl;
		end
	end

	assign out_v   = v_q;
	assign out_rem = rem_q;
	assign out_sh  = sh_q;
	assign out_den = den_q;
	assign out_pl  = pl_q;
endmodule

// File: src/ccw_div.sv
// ----------------------------------------------------------------------------
// ccw_div
// Pipelined divider: a row of QW division cells, one quotient bit each.
// ----------------------------------------------------------------------------
module ccw_div #(
	parameter int DW = 16,
	parameter int QW = 24,
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [DW-1:0] in_rem,
	input  logic [QW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [PW-1:0] in_pl,
	output logic          out_v,
	output logic [QW-1:0] out_quo,
	output logic [PW-1:0] out_pl
);
	logic          v_w   [QW+1];
	logic [DW-1:0] rem_w [QW+1];
	logic [QW-1:0] sh_w  [QW+1];
	logic [DW-1:0] den_w [QW+1];
	logic [PW-1:0] pl_w  [QW+1];

	assign v_w[0]   = in_v;
	assign rem_w[0] = in_rem;
	assign sh_w[0]  = in_num;
	assign den_w[0] = in_den;
	assign pl_w[0]  = in_pl;

	for (genvar i = 0; i < QW; i++) begin : g_cell
		ccw_div_cell #(.DW(DW), .QW(QW), .PW(PW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_v    (v_w[i]),
			.in_rem  (rem_w[i]),
			.in_sh   (sh_w[i]),
			.in_den  (den_w[i]),
			.in_pl   (pl_w[i]),
			.out_v   (v_w[i+1]),
			.out_rem (rem_w[i+1]),
			.out_sh  (sh_w[i+1]),
			.out_den (den_w[i+1]),
			.out_pl  (pl_w[i+1])
		);
	end

	assign out_v   = v_w[QW];
	assign out_quo = sh_w[QW];
	assign out_pl  = pl_w[QW];
endmodule

// File: src/ccw_place.sv
// ----------------------------------------------------------------------------
// ccw_place
// One axis: clamp visible size, apply pan, slide window back inside image.
// ----------------------------------------------------------------------------
module ccw_place
	import ccw_pkg::*;
#(
	parameter int LW = 24,
	parameter int AW = 32
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [AW-1:0]             quo,
	input  logic [LW:0]               centre,
	input  logic [LW-1:0]             limit,
	input  logic signed [FIELD_W-1:0] pan,
	output logic [LW-1:0]             lo,
	output logic [LW-1:0]             size
);
	localparam int PRW = LW + 2 + FIELD_W;

	logic [LW:0]               vis_s1;
	logic [LW:0]               cen_s1;
	logic [LW-1:0]             lim_s1;
	logic signed [FIELD_W-1:0] pan_s1;
	logic signed [PRW-1:0]     prod_s2;
	logic signed [PRW-1:0]     lo0_s2;
	logic [LW:0]               vis_s2;
	logic [LW-1:0]             lim_s2;
	logic signed [PRW-1:0]     lo1_s3;
	logic [LW-1:0]             vis_s3;
	logic [LW-1:0]             lim_s3;
	logic [AW-1:0]             lim_ext;
	logic signed [PRW-1:0]     bias;
	logic signed [PRW-1:0]     off;
	logic signed [PRW-1:0]     lo2;
	logic [PRW-1:0]            far;

	assign lim_ext = AW'(limit);

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s1 <= (quo > lim_ext) ? ({1'b0, limit} + 1'b1) : (LW+1)'(quo);
			cen_s1 <= centre;
			lim_s1 <= limit;
			pan_s1 <= pan;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= PRW'($signed({1'b0, vis_s1}) * pan_s1);
			lo0_s2  <= $signed(PRW'(cen_s1)) - $signed(PRW'(vis_s1 >> 1));
			vis_s2  <= vis_s1;
			lim_s2  <= lim_s1;
		end
	end

	always_comb begin
		bias = prod_s2[PRW-1] ? PRW'((1 << PAN_FRAC) - 1) : '0;
		off  = (prod_s2 + bias) >>> PAN_FRAC;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo1_s3 <= lo0_s2 + off;
			vis_s3 <= (vis_s2 > {1'b0, lim_s2}) ? lim_s2 : vis_s2[LW-1:0];
			lim_s3 <= lim_s2;
		end
	end

	always_comb begin
		lo2 = lo1_s3[PRW-1] ? '0 : lo1_s3;
		far = PRW'(lo2) + PRW'(vis_s3);
		if (far > PRW'(lim_s3)) begin
			lo = lim_s3 - vis_s3;
		end else begin
			lo = lo2[LW-1:0];
		end
		size = vis_s3;
	end
endmodule

// File: src/ccw_checker.sv
// ----------------------------------------------------------------------------
// ccw_checker
// Port-level checks for cover_crop_window, bound to the top level.
// ----------------------------------------------------------------------------
`include "cover_crop_window_assert.svh"

module ccw_checker
	import ccw_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tuser
);
	`CCW_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`CCW_ASSERT_IMP(a_ready_flow, clk, arst_n, 1'b1, s_tready == (!m_tvalid || m_tready))
	`CCW_ASSERT_IMP(a_empty_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata == '0)
	`CCW_ASSERT_IMP(a_stall_keep, clk, arst_n, m_tvalid && !m_tready, !s_tready)
endmodule

bind cover_crop_window ccw_checker u_ccw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
